// ----- rtl/pis_pkg.sv -----
// Shared request codes, sequencer states and port field widths for the interval scheduler.
package pis_pkg;

  // Request codes carried on req_type
  localparam logic [1:0] REQ_REGISTER = 2'd0;
  localparam logic [1:0] REQ_TICK     = 2'd1;
  localparam logic [1:0] REQ_SERVICE  = 2'd2;

  // Sequencer states
  localparam int unsigned ST_W    = 2;
  localparam logic [ST_W-1:0] ST_IDLE = 2'd0;
  localparam logic [ST_W-1:0] ST_SCAN = 2'd1;
  localparam logic [ST_W-1:0] ST_DONE = 2'd2;

  // Fixed port field widths
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned IN_W    = 32;
  localparam int unsigned SLOT_W  = 3;
  localparam int unsigned MASK_W  = 8;
  localparam int unsigned COUNT_W = 4;

endpackage

// ----- rtl/periodic_interval_scheduler_top.sv -----
// Periodic interval scheduler: slot table in RAM, request sequencer and result register.
//
// Usage: one request transaction enters on the input channel (req_type_i, now_ms_i,
// period_ms_i) and gives exactly one result transaction on the output channel.
//   register (0): stores period and start time in the next free slot, returns its index
//                 or table_full_o when all CHANNELS slots are taken.
//   tick     (1): walks every registered slot; elapsed slots get their pending bit set
//                 and their start time reloaded with now_ms_i.
//   service  (2): reports the pending mask and clears it. Code 3 only reports.
// Register, service and code 3 pass from acceptance through ST_DONE to out_valid_o.
// A tick walks the slot table, which is one RAM with a registered read port,
// reading one slot and writing back the previous one each cycle. in_stall_o holds
// new requests off until the result has left ST_DONE for the output register.
// The input is taken while an earlier result still waits in the output register; the
// new result is held until that register frees. A stalled result holds its value.
// Reset clears the slot count, the pending bits and all valid/state flags; the RAM
// needs no clearing since only registered slots are ever read.
module periodic_interval_scheduler_top #(
  parameter int unsigned CHANNELS  = 8,
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [pis_pkg::REQ_W-1:0]     req_type_i,
  input  logic [pis_pkg::IN_W-1:0]      now_ms_i,
  input  logic [pis_pkg::IN_W-1:0]      period_ms_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [pis_pkg::SLOT_W-1:0]    assigned_slot_o,
  output logic                          table_full_o,
  output logic [pis_pkg::MASK_W-1:0]    pending_mask_o,
  output logic [pis_pkg::COUNT_W-1:0]   used_slots_o
);

  localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned CNT_W = $clog2(CHANNELS + 1);
  localparam int unsigned ROW_W = 2 * TIME_BITS;

  // Control state
  logic [pis_pkg::ST_W-1:0] state_q, state_d;
  logic [CNT_W-1:0]         count_q, count_d;
  logic [CHANNELS-1:0]      pend_q, pend_d;
  logic [IDX_W-1:0]         cur_q, cur_d;
  logic                     out_valid_q, out_valid_d;

  // Payload registers
  logic [TIME_BITS-1:0]     now_q, now_d;
  logic [IDX_W-1:0]         res_slot_q, res_slot_d;
  logic                     res_full_q, res_full_d;
  logic [CHANNELS-1:0]      res_pend_q, res_pend_d;
  logic [CNT_W-1:0]         res_count_q, res_count_d;
  logic [IDX_W-1:0]         out_slot_q;
  logic                     out_full_q;
  logic [CHANNELS-1:0]      out_pend_q;
  logic [CNT_W-1:0]         out_count_q;

  // RAM port signals
  logic                     ram_we, ram_re;
  logic [IDX_W-1:0]         ram_waddr, ram_raddr;
  logic [ROW_W-1:0]         ram_wdata, ram_rdata;

  logic                     in_acc;
  logic                     out_free;
  logic                     tbl_full;
  logic [TIME_BITS-1:0]     in_now, in_period;
  logic [TIME_BITS-1:0]     row_period, row_start, elapsed;
  logic                     hit;
  logic [CNT_W-1:0]         next_idx;
  logic                     last;

  assign in_stall_o = (state_q != pis_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign tbl_full   = (count_q == CNT_W'(CHANNELS));
  assign in_now     = TIME_BITS'(now_ms_i);
  assign in_period  = TIME_BITS'(period_ms_i);

  // Slot row read back during the tick walk
  assign row_period = ram_rdata[ROW_W-1:TIME_BITS];
  assign row_start  = ram_rdata[TIME_BITS-1:0];
  assign elapsed    = now_q - row_start;
  assign hit        = (elapsed >= row_period);
  assign next_idx   = CNT_W'(cur_q) + CNT_W'(1);
  assign last       = (next_idx == count_q);

  pis_ram #(
    .WIDTH(ROW_W),
    .DEPTH(CHANNELS)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Request sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    pend_d      = pend_q;
    cur_d       = cur_q;
    now_d       = now_q;
    out_valid_d = out_valid_q;
    res_slot_d  = res_slot_q;
    res_full_d  = res_full_q;
    res_pend_d  = res_pend_q;
    res_count_d = res_count_q;
    ram_we      = 1'b0;
    ram_waddr   = cur_q;
    ram_wdata   = {row_period, now_q};
    ram_re      = 1'b0;
    ram_raddr   = next_idx[IDX_W-1:0];

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      pis_pkg::ST_IDLE: begin
        if (in_acc) begin
          res_slot_d  = '0;
          res_full_d  = 1'b0;
          res_pend_d  = pend_q;
          res_count_d = count_q;
          now_d       = in_now;
          state_d     = pis_pkg::ST_DONE;
          case (req_type_i)
            pis_pkg::REQ_REGISTER: begin
              if (tbl_full) begin
                res_full_d = 1'b1;
              end else begin
                ram_we      = 1'b1;
                ram_waddr   = count_q[IDX_W-1:0];
                ram_wdata   = {in_period, in_now};
                res_slot_d  = count_q[IDX_W-1:0];
                count_d     = count_q + CNT_W'(1);
                res_count_d = count_d;
              end
            end
            pis_pkg::REQ_TICK: begin
              if (count_q != '0) begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                cur_d     = '0;
                state_d   = pis_pkg::ST_SCAN;
              end
            end
            pis_pkg::REQ_SERVICE: begin
              pend_d = '0;
            end
            default: begin
            end
          endcase
        end
      end

      pis_pkg::ST_SCAN: begin
        // check the slot read last cycle, fetch the next one unless this slot is the last
        if (hit) begin
          ram_we = 1'b1;
          pend_d = pend_q | (CHANNELS'(1) << cur_q);
        end
        if (last) begin
          res_pend_d = pend_d;
          state_d    = pis_pkg::ST_DONE;
        end else begin
          ram_re = 1'b1;
          cur_d  = next_idx[IDX_W-1:0];
        end
      end

      pis_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = pis_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = pis_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pis_pkg::ST_IDLE;
      count_q     <= '0;
      pend_q      <= '0;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      cur_q       <= cur_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    now_q       <= now_d;
    res_slot_q  <= res_slot_d;
    res_full_q  <= res_full_d;
    res_pend_q  <= res_pend_d;
    res_count_q <= res_count_d;
    if (state_q == pis_pkg::ST_DONE && out_free) begin
      out_slot_q  <= res_slot_q;
      out_full_q  <= res_full_q;
      out_pend_q  <= res_pend_q;
      out_count_q <= res_count_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign assigned_slot_o = pis_pkg::SLOT_W'(out_slot_q);
  assign table_full_o    = out_full_q;
  assign pending_mask_o  = pis_pkg::MASK_W'(out_pend_q);
  assign used_slots_o    = pis_pkg::COUNT_W'(out_count_q);

  // Checks
  a_scan_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pis_pkg::ST_SCAN) |-> (count_q != '0))
    else $error("tick walk running over an empty table");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CHANNELS))
    else $error("slot count beyond table depth");

  a_rw_disjoint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("RAM read and write hit the same slot");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pis_pkg::ST_DONE && out_valid_q && out_stall_i) |=>
      (state_q == pis_pkg::ST_DONE && out_valid_q))
    else $error("pending result dropped while output stalled");

  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pis_pkg::ST_SCAN) |-> (CNT_W'(cur_q) < count_q))
    else $error("tick walk index past registered slots");

endmodule

// ----- rtl/pis_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
module pis_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic                                 re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
